// ===== rtl/core/hbs_pkg.sv =====
// ============================================================================
// hbs_pkg
// Shared types and constants for the heightmap bilinear sampler: sizes,
// request and response layouts, configuration register indexes.
// ============================================================================
package hbs_pkg;

    // Grid and number format
    localparam int MAX_SIDE    = 256;
    localparam int HEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int SIDE_BITS   = $clog2(MAX_SIDE);
    localparam int DIM_BITS    = $clog2(MAX_SIDE + 1);
    localparam int ADDR_BITS   = 2 * SIDE_BITS;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int GRID_BITS   = SIDE_BITS + FRAC_BITS;

    // Fixed field widths
    localparam int OP_BITS       = 1;
    localparam int INDEX_BITS    = 16;
    localparam int IN_HEIGHT_BITS = 16;
    localparam int POS_BITS      = 24;
    localparam int OUT_HEIGHT_BITS = 16;
    localparam int CFG_DIM_BITS  = 9;
    localparam int INV_BITS      = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    // Position times reciprocal spacing, signed
    localparam int PROD_BITS = POS_BITS + INV_BITS + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERSE_SPACING = 2'd2;

    localparam logic [CFG_DIM_BITS-1:0] GRID_WIDTH_RESET      = 9'd256;
    localparam logic [CFG_DIM_BITS-1:0] GRID_LENGTH_RESET     = 9'd256;
    localparam logic [INV_BITS-1:0]     INVERSE_SPACING_RESET = 16'd256;

    // Request operations
    localparam logic [OP_BITS-1:0] OP_LOAD   = 1'b0;
    localparam logic [OP_BITS-1:0] OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [OP_BITS-1:0]               op;
        logic [INDEX_BITS-1:0]            cell_index;
        logic signed [IN_HEIGHT_BITS-1:0] height_value;
        logic signed [POS_BITS-1:0]       pos_x;
        logic signed [POS_BITS-1:0]       pos_z;
    } req_t;

    typedef struct packed {
        logic signed [OUT_HEIGHT_BITS-1:0] height;
        logic                              inside_res;
    } rsp_t;

    // Clamped grid coordinate of one axis
    typedef struct packed {
        logic                 in_range;
        logic [GRID_BITS-1:0] coord;
    } grid_t;

endpackage

// ===== rtl/core/hbs_ram.sv =====
// ============================================================================
// hbs_ram
// Generic RAM: one write port, two read ports, registered read data that
// holds while the read enable is low.
// ============================================================================
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
    end

endmodule

// ===== rtl/core/heightmap_bilinear_sampler_top.sv =====
// ============================================================================
// heightmap_bilinear_sampler_top
// Height grid store with bilinear sampling: load requests write one cell,
// sample requests return one interpolated height and an inside flag.
// ============================================================================
// Throughput: one request per cycle while req_stall is low, loads and samples mixed freely.
// A sample result appears on rsp after its request passes the multiply, clamp,
//   address, memory read, X lerp and Z lerp stages.
// A load needs no response; it writes the store from stage 4, after the address stage.
// Reset: rst_n clears the valid bits and sets the registers to 256, 256 and
//   256; the height store is not cleared and is undefined until loaded.
module heightmap_bilinear_sampler_top
    import hbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,

    // request channel
    input  logic                     req_valid,
    output logic                     req_stall,
    input  req_t                     req,

    // response channel
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_t                     rsp
);

    localparam int LX_BITS = HEIGHT_BITS + FRAC_BITS + 2;
    localparam int LZ_BITS = LX_BITS + FRAC_BITS + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DIM_BITS-1:0] grid_width_reg;
    logic [CFG_DIM_BITS-1:0] grid_length_reg;
    logic [INV_BITS-1:0]     inv_spacing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_length_reg <= GRID_LENGTH_RESET;
            inv_spacing_reg <= INVERSE_SPACING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:      grid_width_reg  <= cfg_data[CFG_DIM_BITS-1:0];
                CFG_GRID_LENGTH:     grid_length_reg <= cfg_data[CFG_DIM_BITS-1:0];
                CFG_INVERSE_SPACING: inv_spacing_reg <= cfg_data[INV_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Dimensions below 2 act as 2, above the grid side as the grid side.
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_DIM_BITS-1:0] d);
        logic [DIM_BITS-1:0] r;
        if (32'(d) < 2)
        begin
            r = DIM_BITS'(2);
        end
        else if (32'(d) > MAX_SIDE)
        begin
            r = DIM_BITS'(MAX_SIDE);
        end
        else
        begin
            r = DIM_BITS'(d);
        end
        return r;
    endfunction

    logic [DIM_BITS-1:0] dim_w;
    logic [DIM_BITS-1:0] dim_l;

    assign dim_w = clamp_dim(grid_width_reg);
    assign dim_l = clamp_dim(grid_length_reg);

    // Map a scaled position to a grid coordinate clamped to 0 .. dim-1.
    function automatic grid_t to_grid(input logic signed [PROD_BITS-1:0] p,
                                      input logic [DIM_BITS-1:0] dim);
        logic [PROD_BITS-1:0] top;
        logic [PROD_BITS-1:0] cap;
        logic [PROD_BITS-1:0] shifted;
        grid_t                r;
        top     = PROD_BITS'(dim - 1'b1) << (2 * FRAC_BITS);
        cap     = PROD_BITS'(dim - 1'b1) << FRAC_BITS;
        shifted = PROD_BITS'(p) >> FRAC_BITS;
        r.in_range = !p[PROD_BITS-1] && (PROD_BITS'(p) <= top);
        if (p[PROD_BITS-1])
        begin
            r.coord = '0;
        end
        else if (shifted > cap)
        begin
            r.coord = GRID_BITS'(cap);
        end
        else
        begin
            r.coord = GRID_BITS'(shifted);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance together unless the skid
    // register holds a response.
    // ------------------------------------------------------------------
    logic advance;
    logic req_take;
    logic rsp_take;
    logic out_valid_reg;
    logic skid_valid_reg;

    assign advance   = !skid_valid_reg;
    assign req_stall = skid_valid_reg;
    assign req_take  = req_valid && !req_stall;
    assign rsp_take  = out_valid_reg && !rsp_stall;

    // ------------------------------------------------------------------
    // Stage 1: scale positions by the reciprocal spacing
    // ------------------------------------------------------------------
    logic                             s1_valid_reg;
    logic [OP_BITS-1:0]               s1_op_reg;
    logic [INDEX_BITS-1:0]            s1_index_reg;
    logic signed [IN_HEIGHT_BITS-1:0] s1_hval_reg;
    logic signed [PROD_BITS-1:0]      s1_prod_x_reg;
    logic signed [PROD_BITS-1:0]      s1_prod_z_reg;
    logic signed [PROD_BITS-1:0]      s1_prod_x_next;
    logic signed [PROD_BITS-1:0]      s1_prod_z_next;
    logic signed [INV_BITS:0]         inv_s;

    assign inv_s          = $signed({1'b0, inv_spacing_reg});
    assign s1_prod_x_next = PROD_BITS'(req.pos_x * inv_s);
    assign s1_prod_z_next = PROD_BITS'(req.pos_z * inv_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= req.op;
            s1_index_reg  <= req.cell_index;
            s1_hval_reg   <= req.height_value;
            s1_prod_x_reg <= s1_prod_x_next;
            s1_prod_z_reg <= s1_prod_z_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp to the grid, split into cell and fraction, find the
    // upper neighbours
    // ------------------------------------------------------------------
    grid_t                 gx;
    grid_t                 gz;
    logic [SIDE_BITS-1:0]  x0_next;
    logic [SIDE_BITS-1:0]  z0_next;
    logic [SIDE_BITS-1:0]  x1_next;
    logic [SIDE_BITS-1:0]  z1_next;
    logic [DIM_BITS-1:0]   x0_inc;
    logic [DIM_BITS-1:0]   z0_inc;

    assign gx      = to_grid(s1_prod_x_reg, dim_w);
    assign gz      = to_grid(s1_prod_z_reg, dim_l);
    assign x0_next = gx.coord[GRID_BITS-1:FRAC_BITS];
    assign z0_next = gz.coord[GRID_BITS-1:FRAC_BITS];
    assign x0_inc  = DIM_BITS'(x0_next) + 1'b1;
    assign z0_inc  = DIM_BITS'(z0_next) + 1'b1;
    // Clamp the upper neighbour at the last column or row.
    assign x1_next = (x0_inc < dim_w) ? SIDE_BITS'(x0_inc) : SIDE_BITS'(dim_w - 1'b1);
    assign z1_next = (z0_inc < dim_l) ? SIDE_BITS'(z0_inc) : SIDE_BITS'(dim_l - 1'b1);

    logic                             s2_valid_reg;
    logic [OP_BITS-1:0]               s2_op_reg;
    logic [INDEX_BITS-1:0]            s2_index_reg;
    logic signed [IN_HEIGHT_BITS-1:0] s2_hval_reg;
    logic                             s2_inside_reg;
    logic [SIDE_BITS-1:0]             s2_x0_reg;
    logic [SIDE_BITS-1:0]             s2_x1_reg;
    logic [SIDE_BITS-1:0]             s2_z0_reg;
    logic [SIDE_BITS-1:0]             s2_z1_reg;
    logic [FRAC_BITS-1:0]             s2_tx_reg;
    logic [FRAC_BITS-1:0]             s2_tz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_index_reg  <= s1_index_reg;
            s2_hval_reg   <= s1_hval_reg;
            s2_inside_reg <= gx.in_range && gz.in_range;
            s2_x0_reg     <= x0_next;
            s2_x1_reg     <= x1_next;
            s2_z0_reg     <= z0_next;
            s2_z1_reg     <= z1_next;
            s2_tx_reg     <= gx.coord[FRAC_BITS-1:0];
            s2_tz_reg     <= gz.coord[FRAC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: linear cell addresses row * width + column
    // ------------------------------------------------------------------
    logic [ADDR_BITS:0] row0;
    logic [ADDR_BITS:0] row1;

    assign row0 = (ADDR_BITS+1)'(s2_z0_reg) * (ADDR_BITS+1)'(dim_w);
    assign row1 = (ADDR_BITS+1)'(s2_z1_reg) * (ADDR_BITS+1)'(dim_w);

    logic                             s3_valid_reg;
    logic [OP_BITS-1:0]               s3_op_reg;
    logic [INDEX_BITS-1:0]            s3_index_reg;
    logic signed [IN_HEIGHT_BITS-1:0] s3_hval_reg;
    logic                             s3_inside_reg;
    logic [ADDR_BITS-1:0]             s3_a00_reg;
    logic [ADDR_BITS-1:0]             s3_a10_reg;
    logic [ADDR_BITS-1:0]             s3_a01_reg;
    logic [ADDR_BITS-1:0]             s3_a11_reg;
    logic [FRAC_BITS-1:0]             s3_tx_reg;
    logic [FRAC_BITS-1:0]             s3_tz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_index_reg  <= s2_index_reg;
            s3_hval_reg   <= s2_hval_reg;
            s3_inside_reg <= s2_inside_reg;
            s3_a00_reg    <= ADDR_BITS'(row0 + (ADDR_BITS+1)'(s2_x0_reg));
            s3_a10_reg    <= ADDR_BITS'(row0 + (ADDR_BITS+1)'(s2_x1_reg));
            s3_a01_reg    <= ADDR_BITS'(row1 + (ADDR_BITS+1)'(s2_x0_reg));
            s3_a11_reg    <= ADDR_BITS'(row1 + (ADDR_BITS+1)'(s2_x1_reg));
            s3_tx_reg     <= s2_tx_reg;
            s3_tz_reg     <= s2_tz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: height store. Two copies, one per row, each read at two
    // columns; loads write both copies from this stage so that request
    // order is kept.
    // ------------------------------------------------------------------
    logic                   st_wr_en;
    logic [ADDR_BITS-1:0]   st_wr_addr;
    logic [HEIGHT_BITS-1:0] st_wr_data;
    logic [HEIGHT_BITS-1:0] h00_raw;
    logic [HEIGHT_BITS-1:0] h10_raw;
    logic [HEIGHT_BITS-1:0] h01_raw;
    logic [HEIGHT_BITS-1:0] h11_raw;

    // Drop loads beyond the store.
    assign st_wr_en   = advance && s3_valid_reg && (s3_op_reg == OP_LOAD)
                        && (32'(s3_index_reg) < STORE_DEPTH);
    assign st_wr_addr = ADDR_BITS'(s3_index_reg);
    assign st_wr_data = HEIGHT_BITS'(s3_hval_reg);

    hbs_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_row0_ram (
        .clk       (clk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_en     (advance),
        .rd_addr_a (s3_a00_reg),
        .rd_addr_b (s3_a10_reg),
        .rd_data_a (h00_raw),
        .rd_data_b (h10_raw)
    );

    hbs_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_row1_ram (
        .clk       (clk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_en     (advance),
        .rd_addr_a (s3_a01_reg),
        .rd_addr_b (s3_a11_reg),
        .rd_data_a (h01_raw),
        .rd_data_b (h11_raw)
    );

    logic                 s4_valid_reg;
    logic                 s4_inside_reg;
    logic [FRAC_BITS-1:0] s4_tx_reg;
    logic [FRAC_BITS-1:0] s4_tz_reg;

    // Only samples travel past the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg <= s3_valid_reg && (s3_op_reg == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_inside_reg <= s3_inside_reg;
            s4_tx_reg     <= s3_tx_reg;
            s4_tz_reg     <= s3_tz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: lerp along X, exact with FRAC_BITS fraction bits
    // ------------------------------------------------------------------
    logic signed [HEIGHT_BITS:0]   d0;
    logic signed [HEIGHT_BITS:0]   d1;
    logic signed [FRAC_BITS:0]     tx_s;
    logic signed [LX_BITS-1:0]     h0f_next;
    logic signed [LX_BITS-1:0]     h1f_next;

    assign d0   = (HEIGHT_BITS+1)'($signed(h10_raw)) - (HEIGHT_BITS+1)'($signed(h00_raw));
    assign d1   = (HEIGHT_BITS+1)'($signed(h11_raw)) - (HEIGHT_BITS+1)'($signed(h01_raw));
    assign tx_s = $signed({1'b0, s4_tx_reg});
    assign h0f_next = (LX_BITS'($signed(h00_raw)) <<< FRAC_BITS) + LX_BITS'(d0 * tx_s);
    assign h1f_next = (LX_BITS'($signed(h01_raw)) <<< FRAC_BITS) + LX_BITS'(d1 * tx_s);

    logic                      s5_valid_reg;
    logic                      s5_inside_reg;
    logic [FRAC_BITS-1:0]      s5_tz_reg;
    logic signed [LX_BITS-1:0] s5_h0f_reg;
    logic signed [LX_BITS-1:0] s5_h1f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_inside_reg <= s4_inside_reg;
            s5_tz_reg     <= s4_tz_reg;
            s5_h0f_reg    <= h0f_next;
            s5_h1f_reg    <= h1f_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: lerp along Z, floor once by dropping 2*FRAC_BITS bits
    // (arithmetic shift rounds toward minus infinity)
    // ------------------------------------------------------------------
    logic signed [LX_BITS:0]   dz;
    logic signed [FRAC_BITS:0] tz_s;
    logic signed [LZ_BITS-1:0] hz_sum;
    rsp_t                      rsp_next;

    assign dz     = (LX_BITS+1)'(s5_h1f_reg) - (LX_BITS+1)'(s5_h0f_reg);
    assign tz_s   = $signed({1'b0, s5_tz_reg});
    assign hz_sum = (LZ_BITS'(s5_h0f_reg) <<< FRAC_BITS) + LZ_BITS'(dz * tz_s);

    assign rsp_next.height     = hz_sum[2*FRAC_BITS +: OUT_HEIGHT_BITS];
    assign rsp_next.inside_res = s5_inside_reg;

    // ------------------------------------------------------------------
    // Output register plus skid register: a new response lands in the
    // skid register when the output is held, which then freezes the pipe.
    // ------------------------------------------------------------------
    rsp_t out_reg;
    rsp_t skid_reg;
    logic new_rsp;

    assign new_rsp = advance && s5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (new_rsp)
        begin
            if (!out_valid_reg || rsp_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (rsp_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (new_rsp)
        begin
            if (!out_valid_reg || rsp_take)
            begin
                out_reg <= rsp_next;
            end
            else
            begin
                skid_reg <= rsp_next;
            end
        end
        else if (rsp_take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== sim/height_check_pkg.sv =====
// ============================================================================
// height_check_pkg
// Scoreboard for the heightmap bilinear sampler: a shadow height store and
// register set, a fixed-point bilinear predictor, and the queue of expected
// sample responses.
// ============================================================================
package height_check_pkg;

    import hbs_pkg::*;

    localparam longint ONE = longint'(1) <<< FRAC_BITS;

    class height_scoreboard;

        logic signed [IN_HEIGHT_BITS-1:0] heights [STORE_DEPTH];
        bit                               loaded  [STORE_DEPTH];
        logic [CFG_DIM_BITS-1:0]          grid_width;
        logic [CFG_DIM_BITS-1:0]          grid_length;
        logic [INV_BITS-1:0]              inv_spacing;
        rsp_t                             expected_heights [$];
        int                               mismatches;

        function new();
            grid_width  = GRID_WIDTH_RESET;
            grid_length = GRID_LENGTH_RESET;
            inv_spacing = INVERSE_SPACING_RESET;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_GRID_WIDTH:      grid_width  = data[CFG_DIM_BITS-1:0];
                CFG_GRID_LENGTH:     grid_length = data[CFG_DIM_BITS-1:0];
                CFG_INVERSE_SPACING: inv_spacing = data[INV_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Dimensions below 2 act as 2, above the store side as the side
        function int unsigned eff_dim(logic [CFG_DIM_BITS-1:0] d);
            if (d < 2)
                return 2;
            if (d > MAX_SIDE)
                return MAX_SIDE;
            return 32'(d);
        endfunction

        function longint axis_coord(logic [POS_BITS-1:0] pos, int unsigned dim,
                                    inout bit in_bounds);
            longint p;
            longint top;
            longint g;
            longint lim;
            p   = longint'($signed(pos)) * longint'(inv_spacing);
            top = longint'(dim - 1) <<< (2 * FRAC_BITS);
            lim = longint'(dim - 1) <<< FRAC_BITS;
            if (p < 0 || p > top)
                in_bounds = 1'b0;
            g = (p > 0) ? (p >>> FRAC_BITS) : longint'(0);
            if (g > lim)
                g = lim;
            return g;
        endfunction

        // Linear indexes of the four neighbors, order (x0,z0) (x1,z0) (x0,z1) (x1,z1)
        function void corner_cells(req_t r, output int unsigned cells [4],
                                   output longint tx, output longint tz,
                                   output bit in_bounds);
            int unsigned w;
            int unsigned l;
            int unsigned x0;
            int unsigned x1;
            int unsigned z0;
            int unsigned z1;
            longint      gx;
            longint      gz;
            w         = eff_dim(grid_width);
            l         = eff_dim(grid_length);
            in_bounds = 1'b1;
            gx        = axis_coord(r.pos_x, w, in_bounds);
            gz        = axis_coord(r.pos_z, l, in_bounds);
            x0        = 32'(gx >>> FRAC_BITS);
            z0        = 32'(gz >>> FRAC_BITS);
            x1        = (x0 + 1 < w) ? x0 + 1 : w - 1;
            z1        = (z0 + 1 < l) ? z0 + 1 : l - 1;
            tx        = gx - (longint'(x0) <<< FRAC_BITS);
            tz        = gz - (longint'(z0) <<< FRAC_BITS);
            cells[0]  = z0 * w + x0;
            cells[1]  = z0 * w + x1;
            cells[2]  = z1 * w + x0;
            cells[3]  = z1 * w + x1;
        endfunction

        function rsp_t predict_sample(req_t r);
            int unsigned cells [4];
            longint      tx;
            longint      tz;
            longint      h00;
            longint      h10;
            longint      h01;
            longint      h11;
            longint      h0f;
            longint      h1f;
            longint      acc;
            bit          in_bounds;
            rsp_t        want;
            corner_cells(r, cells, tx, tz, in_bounds);
            h00 = longint'(heights[cells[0]]);
            h10 = longint'(heights[cells[1]]);
            h01 = longint'(heights[cells[2]]);
            h11 = longint'(heights[cells[3]]);
            // Exact lerp along X, then Z, one floor at the very end
            h0f = h00 * ONE + (h10 - h00) * tx;
            h1f = h01 * ONE + (h11 - h01) * tx;
            acc = (h0f * ONE + (h1f - h0f) * tz) >>> (2 * FRAC_BITS);
            want.height     = acc[OUT_HEIGHT_BITS-1:0];
            want.inside_res = in_bounds;
            return want;
        endfunction

        function void note_request(req_t r);
            if (r.op == OP_LOAD)
            begin
                heights[r.cell_index] = r.height_value;
                loaded[r.cell_index]  = 1'b1;
            end
            else
                expected_heights = {expected_heights, predict_sample(r)};
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_heights.size() == 0)
            begin
                $error("response with no sample pending: height %0d inside_res %0d",
                       $signed(got.height), got.inside_res);
                mismatches++;
                return;
            end
            want = expected_heights.pop_front();
            if (got.height !== want.height)
            begin
                $error("height: expected %0d, actual %0d",
                       $signed(want.height), $signed(got.height));
                mismatches++;
            end
            if (got.inside_res !== want.inside_res)
            begin
                $error("inside_res: expected %0d, actual %0d",
                       want.inside_res, got.inside_res);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_heights.size();
        endfunction

    endclass

endpackage

// ===== sim/testbench.sv =====
// ============================================================================
// testbench
// Drives load and sample requests into the heightmap bilinear sampler under
// random idling and response stalls, predicts every sample response with a
// fixed-point bilinear model, and checks responses in order.
// ============================================================================
module testbench;

    import hbs_pkg::*;
    import height_check_pkg::*;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_PCT        = 16;
    localparam int LOAD_PCT        = 40;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int SETTLE_CYCLES   = 12;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     req_valid;
    logic                     req_stall;
    req_t                     req;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    rsp_t                     rsp;

    // High while neither side may idle
    bit                       steady;
    height_scoreboard         sb;

    heightmap_bilinear_sampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Stall the response side at random, except during the steady stretch
    always @(negedge clk)
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    // Check every accepted response against the oldest prediction
    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);

    // Hard stop in case the block hangs or drops responses
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Fill every bit with noise; callers then set the fields that matter
    function automatic req_t random_request();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(req_t)-1:0];
    endfunction

    // Pick a position along one axis for the current spacing: mostly inside
    // the grid, some right on the far edge, some anywhere at all
    function automatic logic [POS_BITS-1:0] random_pos(int unsigned dim);
        longint span;
        longint raw;
        longint inv;
        inv  = longint'(sb.inv_spacing);
        span = longint'(dim - 1) <<< (2 * FRAC_BITS);
        case ($urandom_range(9))
            0, 1:
                return POS_BITS'($urandom);
            2:
                raw = (inv == 0) ? longint'(0)
                                 : span / inv + longint'($urandom_range(4)) - 2;
            default:
                raw = (inv == 0) ? longint'($urandom)
                                 : longint'($urandom_range(32'(span))) / inv;
        endcase
        if (raw > longint'(24'h7fffff))
            raw = longint'(24'h7fffff);
        return raw[POS_BITS-1:0];
    endfunction

    // Present one request from a falling edge, idling first at random, and
    // hold it until accepted; return at the falling edge after acceptance
    task automatic send_request(req_t r);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic load_cell(logic [INDEX_BITS-1:0] idx, logic [IN_HEIGHT_BITS-1:0] value);
        req_t r;
        r              = random_request();
        r.op           = OP_LOAD;
        r.cell_index   = idx;
        r.height_value = value;
        send_request(r);
    endtask

    // Load any neighbor that was never written before sampling, so the block
    // never reads an undefined cell
    task automatic sample_at(logic [POS_BITS-1:0] px, logic [POS_BITS-1:0] pz);
        req_t        r;
        int unsigned cells [4];
        longint      tx;
        longint      tz;
        bit          in_bounds;
        r       = random_request();
        r.op    = OP_SAMPLE;
        r.pos_x = px;
        r.pos_z = pz;
        sb.corner_cells(r, cells, tx, tz, in_bounds);
        foreach (cells[i])
            if (!sb.loaded[cells[i]])
                load_cell(INDEX_BITS'(cells[i]), IN_HEIGHT_BITS'($urandom));
        send_request(r);
    endtask

    // Drop valid and hold off until every sample has answered, then let
    // in-flight loads settle
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Leave the write enable high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic random_item();
        int unsigned w;
        int unsigned l;
        w = sb.eff_dim(sb.grid_width);
        l = sb.eff_dim(sb.grid_length);
        if ($urandom_range(99) < LOAD_PCT)
        begin
            // Half the loads refresh the grid in use, half land anywhere
            if ($urandom_range(1) == 0)
                load_cell(INDEX_BITS'($urandom_range(w * l - 1)), IN_HEIGHT_BITS'($urandom));
            else
                load_cell(INDEX_BITS'($urandom), IN_HEIGHT_BITS'($urandom));
        end
        else
            sample_at(random_pos(w), random_pos(l));
    endtask

    // Reconfigure while idle, then run a batch of random requests. Junk goes
    // into the unused upper bits of the dimension writes.
    task automatic run_phase(logic [CFG_DIM_BITS-1:0] w, logic [CFG_DIM_BITS-1:0] l,
                             logic [INV_BITS-1:0] inv, bit no_idle);
        drain();
        write_reg(CFG_GRID_WIDTH, {7'($urandom), w});
        write_reg(CFG_GRID_LENGTH, {7'($urandom), l});
        write_reg(CFG_INVERSE_SPACING, inv);
        write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
        steady = no_idle;
        repeat (ITEMS_PER_PHASE)
            random_item();
        steady = 1'b0;
    endtask

    initial
    begin
        sb        = new();
        steady    = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data  = '0;
        req_valid = 1'b0;
        req       = '0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on the reset geometry (256 x 256, spacing 1.0).
        // Opposite extreme heights around both corners exercise the full
        // lerp range and the floor of negative fractions.
        load_cell(16'd0, 16'h7fff);
        load_cell(16'd1, 16'h8000);
        load_cell(16'd256, 16'h8000);
        load_cell(16'd257, 16'h7fff);
        load_cell(16'd65278, 16'h8000);
        load_cell(16'd65279, 16'h7fff);
        load_cell(16'd65534, 16'h7fff);
        load_cell(16'd65535, 16'h8000);
        sample_at(24'h000000, 24'h000000);   // exact origin
        sample_at(24'h000080, 24'h000040);   // fractional, negative result
        sample_at(24'h0000c0, 24'h0000ff);
        sample_at(24'h00fe80, 24'h00fe80);   // interior of the far cell
        sample_at(24'h00ff00, 24'h00ff00);   // far edge exactly, neighbors clamp
        sample_at(24'h00ff01, 24'h000000);   // just past the far edge
        sample_at(24'hffffff, 24'h000010);   // just below zero
        sample_at(24'h7fffff, 24'h7fffff);   // most positive
        sample_at(24'h800000, 24'h800000);   // most negative

        // Geometry sweep: smallest and largest grids, dimensions outside the
        // legal range, zero, minimum and maximum spacing, then random ones
        run_phase(9'd2, 9'd2, 16'd256, 1'b0);
        run_phase(9'd256, 9'd2, 16'd37, 1'b0);
        run_phase(9'd2, 9'd256, 16'd1000, 1'b0);
        run_phase(9'd0, 9'd1, 16'd0, 1'b0);
        run_phase(9'd12, 9'd9, 16'd300, 1'b1);
        run_phase(9'd511, 9'd300, 16'hffff, 1'b0);
        run_phase(9'd16, 9'd8, 16'd1, 1'b0);
        repeat (3)
            run_phase(9'($urandom_range(20, 2)), 9'($urandom_range(20, 2)),
                      16'($urandom_range(65535, 1)), 1'b0);
        run_phase(GRID_WIDTH_RESET, GRID_LENGTH_RESET, INVERSE_SPACING_RESET, 1'b0);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
